>>> design/playfair_digraph_cipher_assert.svh
// Assertion macros used by the Playfair cipher checker.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define PFDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define PFDC_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

>>> design/pfdc_pkg.sv
// Types, constants and helper functions of the Playfair cipher block.
package pfdc_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = 25;
    localparam int LETTERS = 26;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] coord_t;

    localparam letter_t LETTER_I   = 5'd8;
    localparam letter_t LETTER_J   = 5'd9;
    localparam letter_t LETTER_X   = 5'd23;
    localparam letter_t LETTER_MAX = 5'd25;
    localparam letter_t LAST_CELL  = 5'd24;
    localparam coord_t  LAST_COORD = 3'd4;

    typedef enum logic [1:0] {
        FUNC_KEY    = 2'd0,
        FUNC_FINISH = 2'd1,
        FUNC_TEXT   = 2'd2,
        FUNC_END    = 2'd3
    } func_t;

    typedef struct packed {
        func_t   func;
        letter_t letter;
    } in_t;

    typedef struct packed {
        letter_t out_letter;
        logic    last_of_pair;
    } out_t;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILLER  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_CMP,
        ST_POS,
        ST_RDA,
        ST_LDA,
        ST_RDB,
        ST_LDB
    } state_t;

    typedef struct packed {
        logic take;
        logic fill_step;
        logic scan_step;
        logic pos_calc;
        logic rd_a;
        logic rd_b;
        logic load_a;
        logic load_b;
    } cmd_t;

    typedef struct packed {
        logic fill_go;
        logic pair_go;
        logic fill_last;
        logic scan_last;
        logic out_free;
    } status_t;

    function automatic letter_t fold(letter_t v);
        return (v == LETTER_J) ? LETTER_I : v;
    endfunction

    // Move one place along a row or column, wrapping at the edge.
    function automatic coord_t step_coord(coord_t x, logic dec);
        coord_t r;
        if (dec)
            r = (x == 3'd0) ? LAST_COORD : x - 3'd1;
        else
            r = (x == LAST_COORD) ? 3'd0 : x + 3'd1;
        return r;
    endfunction

    // Linear cell index: row * 5 + col.
    function automatic letter_t cell_addr(coord_t row, coord_t col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

endpackage

>>> design/pfdc_datapath.sv
// Datapath: square memory, key and pairing state, position search and output register.
module pfdc_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  pfdc_pkg::in_t                 in_data,
    input  logic                          cfg_write,
    input  logic [pfdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfdc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  pfdc_pkg::cmd_t                cmd,
    output pfdc_pkg::status_t             status,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pfdc_pkg::out_t                out_data
);

    pfdc_pkg::letter_t square_mem [pfdc_pkg::CELLS];

    logic                       decrypt_reg;
    pfdc_pkg::letter_t          filler_reg;
    logic [pfdc_pkg::LETTERS-1:0] used_reg, used_next;
    pfdc_pkg::letter_t          fill_reg, fill_next;
    logic                       key_done_reg, key_done_next;
    pfdc_pkg::letter_t          pend_reg, pend_next;
    logic                       pend_valid_reg, pend_valid_next;
    pfdc_pkg::letter_t          cnt_reg, cnt_next;
    pfdc_pkg::coord_t           row_reg, row_next, col_reg, col_next;
    pfdc_pkg::coord_t           drow_reg, drow_next, dcol_reg, dcol_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    pfdc_pkg::letter_t          a_reg, a_next, b_reg, b_next;
    logic                       fa_reg, fa_next, fb_reg, fb_next;
    pfdc_pkg::coord_t           ra_reg, ra_next, ca_reg, ca_next;
    pfdc_pkg::coord_t           rb_reg, rb_next, cb_reg, cb_next;
    pfdc_pkg::letter_t          ya_reg, ya_next, yb_reg, yb_next;
    pfdc_pkg::letter_t          rdata_reg;
    logic                       out_valid_reg, out_valid_next;
    pfdc_pkg::out_t             out_data_reg, out_data_next;

    pfdc_pkg::letter_t          fv;
    pfdc_pkg::letter_t          filler_eff;
    logic                       in_ok;
    logic                       place_en;
    pfdc_pkg::letter_t          place_v;
    pfdc_pkg::letter_t          rd_addr;
    logic                       rd_en;

    assign fv         = pfdc_pkg::fold(in_data.letter);
    assign in_ok      = (in_data.letter <= pfdc_pkg::LETTER_MAX);
    assign filler_eff = pfdc_pkg::fold((filler_reg > pfdc_pkg::LETTER_MAX) ?
                                       pfdc_pkg::LETTER_X : filler_reg);

    always_comb
    begin
        status.fill_go   = (in_data.func == pfdc_pkg::FUNC_FINISH) && !key_done_reg;
        status.pair_go   = key_done_reg && pend_valid_reg &&
                           (((in_data.func == pfdc_pkg::FUNC_TEXT) && in_ok) ||
                            (in_data.func == pfdc_pkg::FUNC_END));
        status.fill_last = (cnt_reg == pfdc_pkg::LETTER_MAX);
        status.scan_last = (cnt_reg == pfdc_pkg::LAST_CELL);
        status.out_free  = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        used_next       = used_reg;
        fill_next       = fill_reg;
        key_done_next   = key_done_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        drow_next       = drow_reg;
        dcol_next       = dcol_reg;
        cmp_vld_next    = cmd.scan_step;
        a_next          = a_reg;
        b_next          = b_reg;
        fa_next         = fa_reg;
        fb_next         = fb_reg;
        ra_next         = ra_reg;
        ca_next         = ca_reg;
        rb_next         = rb_reg;
        cb_next         = cb_reg;
        ya_next         = ya_reg;
        yb_next         = yb_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        place_en        = 1'b0;
        place_v         = fv;

        if (cmd.take)
        begin
            case (in_data.func)
                pfdc_pkg::FUNC_KEY:
                begin
                    if (!key_done_reg && in_ok && !used_reg[fv])
                        place_en = 1'b1;
                end
                pfdc_pkg::FUNC_FINISH:
                begin
                    if (status.fill_go)
                        cnt_next = '0;
                end
                pfdc_pkg::FUNC_TEXT:
                begin
                    if (key_done_reg && in_ok && !pend_valid_reg)
                    begin
                        pend_next       = fv;
                        pend_valid_next = 1'b1;
                    end
                    else if (status.pair_go)
                    begin
                        a_next          = pend_reg;
                        b_next          = (fv == pend_reg) ? filler_eff : fv;
                        pend_valid_next = (fv == pend_reg);
                    end
                end
                default:
                begin
                    if (status.pair_go)
                    begin
                        a_next          = pend_reg;
                        b_next          = filler_eff;
                        pend_valid_next = 1'b0;
                    end
                end
            endcase
            if (status.pair_go)
            begin
                cnt_next = '0;
                row_next = '0;
                col_next = '0;
                fa_next  = 1'b0;
                fb_next  = 1'b0;
                ra_next  = '0;
                ca_next  = '0;
                rb_next  = '0;
                cb_next  = '0;
            end
        end

        // Finish: sweep the alphabet, placing every unused letter but j.
        if (cmd.fill_step)
        begin
            if ((cnt_reg != pfdc_pkg::LETTER_J) && !used_reg[cnt_reg])
            begin
                place_en = 1'b1;
                place_v  = cnt_reg;
            end
            cnt_next = cnt_reg + 5'd1;
            if (status.fill_last)
                key_done_next = 1'b1;
        end

        if (place_en)
        begin
            if (fill_reg < pfdc_pkg::LETTER_MAX)
                fill_next = fill_reg + 5'd1;
            used_next = used_reg | (26'd1 << place_v);
            if (place_v == pfdc_pkg::LETTER_I)
                used_next[pfdc_pkg::LETTER_J] = 1'b1;
        end

        if (cmd.scan_step)
        begin
            cnt_next  = cnt_reg + 5'd1;
            drow_next = row_reg;
            dcol_next = col_reg;
            if (col_reg == pfdc_pkg::LAST_COORD)
            begin
                col_next = '0;
                row_next = row_reg + 3'd1;
            end
            else
                col_next = col_reg + 3'd1;
        end

        // Keep the first match of each letter.
        if (cmp_vld_reg)
        begin
            if (!fa_reg && (rdata_reg == a_reg))
            begin
                fa_next = 1'b1;
                ra_next = drow_reg;
                ca_next = dcol_reg;
            end
            if (!fb_reg && (rdata_reg == b_reg))
            begin
                fb_next = 1'b1;
                rb_next = drow_reg;
                cb_next = dcol_reg;
            end
        end

        if (cmd.pos_calc)
        begin
            if (ra_reg == rb_reg)
            begin
                ya_next = pfdc_pkg::cell_addr(ra_reg, pfdc_pkg::step_coord(ca_reg, decrypt_reg));
                yb_next = pfdc_pkg::cell_addr(rb_reg, pfdc_pkg::step_coord(cb_reg, decrypt_reg));
            end
            else if (ca_reg == cb_reg)
            begin
                ya_next = pfdc_pkg::cell_addr(pfdc_pkg::step_coord(ra_reg, decrypt_reg), ca_reg);
                yb_next = pfdc_pkg::cell_addr(pfdc_pkg::step_coord(rb_reg, decrypt_reg), cb_reg);
            end
            else
            begin
                ya_next = pfdc_pkg::cell_addr(ra_reg, cb_reg);
                yb_next = pfdc_pkg::cell_addr(rb_reg, ca_reg);
            end
        end

        if (cmd.load_a || cmd.load_b)
        begin
            out_valid_next             = 1'b1;
            out_data_next.out_letter   = rdata_reg;
            out_data_next.last_of_pair = cmd.load_b;
        end
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        rd_en   = cmd.scan_step || cmd.rd_a || cmd.rd_b;
        rd_addr = cnt_reg;
        if (cmd.rd_a)
            rd_addr = ya_reg;
        else if (cmd.rd_b)
            rd_addr = yb_reg;
    end

    always_ff @(posedge clk)
    begin
        if (place_en && (fill_reg < pfdc_pkg::LETTER_MAX))
            square_mem[fill_reg] <= place_v;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= square_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decrypt_reg    <= 1'b0;
            filler_reg     <= pfdc_pkg::LETTER_X;
            used_reg       <= '0;
            fill_reg       <= '0;
            key_done_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            fa_reg         <= 1'b0;
            fb_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    pfdc_pkg::CFG_DECRYPT: decrypt_reg <= cfg_data[0];
                    default:               filler_reg  <= cfg_data;
                endcase
            end
            used_reg       <= used_next;
            fill_reg       <= fill_next;
            key_done_reg   <= key_done_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            cmp_vld_reg    <= cmp_vld_next;
            fa_reg         <= fa_next;
            fb_reg         <= fb_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        drow_reg     <= drow_next;
        dcol_reg     <= dcol_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        ra_reg       <= ra_next;
        ca_reg       <= ca_next;
        rb_reg       <= rb_next;
        cb_reg       <= cb_next;
        ya_reg       <= ya_next;
        yb_reg       <= yb_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> design/pfdc_ctrl.sv
// Controller: sequences key fill, letter search and output of each pair.
module pfdc_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pfdc_pkg::status_t status,
    output pfdc_pkg::cmd_t    cmd
);

    pfdc_pkg::state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfdc_pkg::ST_IDLE:
            begin
                if (in_valid && status.fill_go)
                    state_next = pfdc_pkg::ST_FILL;
                else if (in_valid && status.pair_go)
                    state_next = pfdc_pkg::ST_SCAN;
            end
            pfdc_pkg::ST_FILL:
            begin
                if (status.fill_last)
                    state_next = pfdc_pkg::ST_IDLE;
            end
            pfdc_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                    state_next = pfdc_pkg::ST_CMP;
            end
            pfdc_pkg::ST_CMP: state_next = pfdc_pkg::ST_POS;
            pfdc_pkg::ST_POS: state_next = pfdc_pkg::ST_RDA;
            pfdc_pkg::ST_RDA: state_next = pfdc_pkg::ST_LDA;
            pfdc_pkg::ST_LDA:
            begin
                if (status.out_free)
                    state_next = pfdc_pkg::ST_RDB;
            end
            pfdc_pkg::ST_RDB: state_next = pfdc_pkg::ST_LDB;
            pfdc_pkg::ST_LDB:
            begin
                if (status.out_free)
                    state_next = pfdc_pkg::ST_IDLE;
            end
            default: state_next = pfdc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != pfdc_pkg::ST_IDLE);
        unique case (state_reg)
            pfdc_pkg::ST_IDLE: cmd.take      = in_valid;
            pfdc_pkg::ST_FILL: cmd.fill_step = 1'b1;
            pfdc_pkg::ST_SCAN: cmd.scan_step = 1'b1;
            pfdc_pkg::ST_CMP:  cmd           = '0;
            pfdc_pkg::ST_POS:  cmd.pos_calc  = 1'b1;
            pfdc_pkg::ST_RDA:  cmd.rd_a      = 1'b1;
            pfdc_pkg::ST_LDA:  cmd.load_a    = status.out_free;
            pfdc_pkg::ST_RDB:  cmd.rd_b      = 1'b1;
            pfdc_pkg::ST_LDB:  cmd.load_b    = status.out_free;
            default:           cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pfdc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> design/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: controller plus datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------
//  in      | request   | in_valid / in_stall    | in_data  {func, letter}
//  out     | result    | out_valid / out_stall  | out_data {out_letter, last_of_pair}
//  cfg     | write     | cfg_write              | cfg_index, cfg_data
//
// A key letter, an ignored request or a text letter that only becomes pending
// does not stall the input. A finish request stalls it while the alphabet sweep
// places one letter a cycle. A pair-closing request scans the square through its
// one read port, compares, locates and reads out both; out_stall can hold it.
// The output register lets the next request in while the last letter waits.
// Reset (rst_n low, async) clears control, key and registers; filler starts as x.
module playfair_digraph_cipher
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pfdc_pkg::in_t                 in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pfdc_pkg::out_t                out_data,
    input  logic                          cfg_write,
    input  logic [pfdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfdc_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Commands from the controller, status back from the datapath.
    pfdc_pkg::cmd_t    cmd;
    pfdc_pkg::status_t status;

    // Sequence each request; stall the input while a request is in work.
    pfdc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold the square, the key and pairing state, and the output register.
    pfdc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> design/pfdc_checker.sv
// Port-level checker for the Playfair cipher, bound to the top level.
`include "playfair_digraph_cipher_assert.svh"

module pfdc_checker
(
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_stall,
    input pfdc_pkg::in_t  in_data,
    input logic           out_valid,
    input logic           out_stall,
    input pfdc_pkg::out_t out_data
);

    logic key_take;
    logic out_held;
    logic out_second;
    logic pair_end;
    logic letter_ok;

    assign key_take   = in_valid && !in_stall && (in_data.func == pfdc_pkg::FUNC_KEY);
    assign out_held   = out_valid && out_stall;
    assign out_second = out_valid && out_data.last_of_pair;
    assign pair_end   = out_second && !out_stall;
    assign letter_ok  = (out_data.out_letter <= pfdc_pkg::LETTER_MAX) &&
                        (out_data.out_letter != pfdc_pkg::LETTER_J);

    // A stalled result holds.
    `PFDC_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_data), "stall dropped")

    // A key letter never holds up the next request.
    `PFDC_ASSERT_NEXT(a_key_fast, key_take, !in_stall, "key letter stalled input")

    // After the second letter of a pair leaves, the next one shown opens a pair.
    `PFDC_ASSERT_NEXT(a_pair_order, pair_end, !out_second, "second letter repeated")

    // The square never holds j or a code past z.
    `PFDC_ASSERT(a_letter_ok, out_valid |-> letter_ok, "bad output letter")

endmodule

bind playfair_digraph_cipher pfdc_checker u_pfdc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
